>>> rtl/somwin_pkg.sv
`default_nettype none
package somwin_pkg;

	localparam int VALUE_BITS = 16;
	localparam int SUM_W      = 22;
	localparam int DIST_W     = 21;
	localparam int HIT_W      = 16;
	localparam int IDX_W      = 8;
	localparam int NET_REGS   = 4;
	localparam int START_W    = 10;

	localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [HIT_W-1:0]  HIT_MAX  = {HIT_W{1'b1}};

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_FEATURE = 2'd1,
		OP_READ    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN
	} state_t;

	typedef enum logic {
		KIND_WIN  = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	localparam logic [2:0] CFG_FEATURES = 3'd0;
	localparam logic [2:0] CFG_NETS     = 3'd1;
	localparam logic [2:0] CFG_NET0     = 3'd2;
	localparam logic [2:0] CFG_NET1     = 3'd3;
	localparam logic [2:0] CFG_NET2     = 3'd4;
	localparam logic [2:0] CFG_NET3     = 3'd5;

	typedef struct packed {
		logic                  load_en;
		logic                  feat_en;
		logic                  feat_zero;
		logic [3:0]            feature;
		logic [IDX_W-1:0]      neuron;
		logic [VALUE_BITS-1:0] value;
	} cell_cmd_t;

	typedef struct packed {
		logic             load;
		logic             shift;
		logic             bump_en;
		logic [IDX_W-1:0] bump_idx;
	} scan_ctl_t;

	typedef struct packed {
		logic [SUM_W-1:0] total;
		logic [HIT_W-1:0] hit;
	} scan_word_t;

endpackage
`default_nettype wire

>>> rtl/somwin_cell.sv
`default_nettype none
module somwin_cell #(
	parameter int MAX_FEATURES = 16,
	parameter int IDX          = 0
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire somwin_pkg::cell_cmd_t  cmd,
	input  wire somwin_pkg::scan_ctl_t  ctl,
	input  wire somwin_pkg::scan_word_t scan_in,
	output somwin_pkg::scan_word_t      scan_out
);
	import somwin_pkg::*;

	localparam int FIDX = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

	logic [VALUE_BITS-1:0] center_q [MAX_FEATURES];
	logic [SUM_W-1:0]      sum_q;
	logic [HIT_W-1:0]      hit_q;
	scan_word_t            scan_q;

	logic [7:0]            fext;
	logic [FIDX-1:0]       faddr;
	logic                  is_me;
	logic                  fin_range;
	logic [VALUE_BITS-1:0] cval;
	logic [VALUE_BITS:0]   diff;
	logic [VALUE_BITS:0]   mag;
	logic [SUM_W:0]        acc;

	assign fext      = {4'd0, cmd.feature};
	assign faddr     = fext[FIDX-1:0];
	assign fin_range = (int'(cmd.feature) < MAX_FEATURES);
	assign is_me     = (cmd.neuron == IDX_W'(IDX));
	assign cval      = center_q[faddr];
	assign diff      = {cmd.value[VALUE_BITS-1], cmd.value} - {cval[VALUE_BITS-1], cval};
	assign mag       = diff[VALUE_BITS] ? (~diff + 1'b1) : diff;
	assign acc       = (cmd.feat_zero ? '0 : {1'b0, sum_q}) + (SUM_W+1)'(mag);

	always_ff @(posedge clk) begin
		if (cmd.load_en && is_me && fin_range) begin
			center_q[faddr] <= cmd.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			hit_q <= '0;
		end else begin
			if (cmd.feat_en) begin
				sum_q <= acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
			end
			if (ctl.bump_en && (ctl.bump_idx == IDX_W'(IDX)) && (hit_q != HIT_MAX)) begin
				hit_q <= hit_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			scan_q <= '{total: sum_q, hit: hit_q};
		end else if (ctl.shift) begin
			scan_q <= scan_in;
		end
	end

	assign scan_out = scan_q;

endmodule
`default_nettype wire

>>> rtl/som_winner_search_hit_count.sv
// Winner search over a self-organizing map with L1 distance and hit counters.
// Input requests arrive on s_tvalid/s_tready with the operation in s_tuser:
// load a center value, stream a data feature, or read back a hit counter.
// Results leave on m_tvalid/m_tready; m_tuser tells a net winner from a
// readback and m_tlast marks the final result of one request.
// Center loads and features other than the last of a point give no result.
// The last feature starts a search: the sums are copied into the scan chain,
// then the chain is scanned over the neurons of the used nets, and each net,
// an empty one too, gives one result.
// A readback copies the hit counters into the chain the same way and shifts
// until the requested neuron reaches cell zero. The chain shifts one neuron per
// cycle toward cell zero, and waits at a result while the output register is full.
// Reset clears all distance sums, hit counters and the output valid flag and
// sets the registers to their defaults; centers must be loaded before use.
// When the receiver stalls the result is held and the scan stops when it reaches
// its next result; no new request is taken until the search or readback has placed
// its last result in the output register.
`default_nettype none
module som_winner_search_hit_count #(
	parameter int MAX_NEURONS  = 64,
	parameter int MAX_FEATURES = 16,
	parameter int MAX_NETS     = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // neuron[5:0], feature[9:6], value[25:10]
	input  wire logic [1:0]  s_tuser,  // op[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // net_index[1:0], winner_neuron[7:2],
	                                   // min_distance[28:8], hit_count[44:29]
	output logic             m_tuser,  // kind[0]
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [6:0]  cfg_data
);
	import somwin_pkg::*;

	localparam int NET_LIMIT = (MAX_NETS < NET_REGS) ? MAX_NETS : NET_REGS;

	logic [4:0]         fc_q;
	logic [2:0]         nc_q;
	logic [6:0]         size_q [NET_REGS];

	state_t             state_q, state_d;
	logic               mode_read_q, mode_read_d;
	logic               oob_q, oob_d;
	logic [5:0]         target_q, target_d;
	logic [START_W-1:0] idx_q, idx_d;
	logic [START_W-1:0] start_q, start_d;
	logic [2:0]         net_q, net_d;
	logic [SUM_W-1:0]   best_d_q, best_d_d;
	logic [START_W-1:0] best_i_q, best_i_d;
	logic [HIT_W-1:0]   best_h_q, best_h_d;

	logic               out_valid_q;
	logic               out_kind_q;
	logic [1:0]         out_net_q;
	logic [5:0]         out_win_q;
	logic [DIST_W-1:0]  out_dist_q;
	logic [HIT_W-1:0]   out_hit_q;
	logic               out_last_q;

	logic               emit;
	logic               e_kind;
	logic [1:0]         e_net;
	logic [5:0]         e_win;
	logic [DIST_W-1:0]  e_dist;
	logic [HIT_W-1:0]   e_hit;
	logic               e_last;

	cell_cmd_t          cmd;
	scan_ctl_t          ctl;
	scan_word_t         chain [MAX_NEURONS+1];
	scan_word_t         head;

	op_t                op;
	logic [5:0]         in_neuron;
	logic [3:0]         in_feature;
	logic               accept;
	logic [6:0]         fc_eff;
	logic [2:0]         nets_eff;
	logic [6:0]         size_cur;
	logic [START_W-1:0] end_raw, end_c, start_next;
	logic               empty, out_free, is_last_net, at_end, take_cur;
	logic [SUM_W-1:0]   cand_d;
	logic [START_W-1:0] cand_i, win_off;
	logic [HIT_W-1:0]   cand_h;

	assign op         = op_t'(s_tuser);
	assign in_neuron  = s_tdata[5:0];
	assign in_feature = s_tdata[9:6];
	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;

	always_comb begin
		if (fc_q == 5'd0) fc_eff = 7'd1;
		else if (int'(fc_q) > MAX_FEATURES) fc_eff = 7'(MAX_FEATURES);
		else fc_eff = {2'd0, fc_q};
		if (nc_q == 3'd0) nets_eff = 3'd1;
		else if (int'(nc_q) > NET_LIMIT) nets_eff = 3'(NET_LIMIT);
		else nets_eff = nc_q;
	end

	assign cmd.load_en   = accept && (op == OP_LOAD);
	assign cmd.feat_en   = accept && (op == OP_FEATURE) && ({3'd0, in_feature} < fc_eff);
	assign cmd.feat_zero = (in_feature == 4'd0);
	assign cmd.feature   = in_feature;
	assign cmd.neuron    = IDX_W'(in_neuron);
	assign cmd.value     = s_tdata[25:10];

	assign chain[MAX_NEURONS] = '0;
	for (genvar i = 0; i < MAX_NEURONS; i++) begin : g_cell
		somwin_cell #(
			.MAX_FEATURES(MAX_FEATURES),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.cmd(cmd),
			.ctl(ctl),
			.scan_in(chain[i+1]),
			.scan_out(chain[i])
		);
	end
	assign head = chain[0];

	assign size_cur    = size_q[net_q[1:0]];
	assign end_raw     = start_q + START_W'(size_cur);
	assign end_c       = (end_raw > START_W'(MAX_NEURONS)) ? START_W'(MAX_NEURONS) : end_raw;
	assign start_next  = end_c;
	assign empty       = (start_q >= end_c);
	assign out_free    = !out_valid_q || m_tready;
	assign is_last_net = ((net_q + 3'd1) == nets_eff);
	assign at_end      = ((idx_q + 1'b1) == end_c);
	assign take_cur    = (idx_q == start_q) || (head.total < best_d_q);
	assign cand_d      = take_cur ? head.total : best_d_q;
	assign cand_i      = take_cur ? idx_q : best_i_q;
	assign cand_h      = take_cur ? head.hit : best_h_q;
	assign win_off     = cand_i - start_q;

	always_comb begin
		state_d     = state_q;
		mode_read_d = mode_read_q;
		oob_d       = oob_q;
		target_d    = target_q;
		idx_d       = idx_q;
		start_d     = start_q;
		net_d       = net_q;
		best_d_d    = best_d_q;
		best_i_d    = best_i_q;
		best_h_d    = best_h_q;
		ctl         = '0;
		emit        = 1'b0;
		e_kind      = KIND_WIN;
		e_net       = net_q[1:0];
		e_win       = '0;
		e_dist      = '0;
		e_hit       = '0;
		e_last      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (op == OP_FEATURE) &&
				    (({3'd0, in_feature} + 7'd1) == fc_eff)) begin
					state_d     = ST_LOAD;
					mode_read_d = 1'b0;
				end else if (accept && (op == OP_READ)) begin
					state_d     = ST_LOAD;
					mode_read_d = 1'b1;
					target_d    = in_neuron;
					oob_d       = (int'(in_neuron) >= MAX_NEURONS);
				end
			end
			ST_LOAD: begin
				ctl.load = 1'b1;
				idx_d    = '0;
				start_d  = '0;
				net_d    = '0;
				state_d  = ST_SCAN;
			end
			ST_SCAN: begin
				if (mode_read_q) begin
					if (oob_q || (idx_q == START_W'(target_q))) begin
						if (out_free) begin
							emit    = 1'b1;
							e_kind  = KIND_READ;
							e_net   = '0;
							e_hit   = oob_q ? '0 : head.hit;
							e_last  = 1'b1;
							state_d = ST_IDLE;
						end
					end else begin
						ctl.shift = 1'b1;
						idx_d     = idx_q + 1'b1;
					end
				end else if (empty) begin
					if (out_free) begin
						emit    = 1'b1;
						e_dist  = DIST_MAX;
						e_last  = is_last_net;
						net_d   = net_q + 3'd1;
						start_d = start_next;
						if (is_last_net) state_d = ST_IDLE;
					end
				end else if (at_end) begin
					if (out_free) begin
						emit         = 1'b1;
						e_win        = win_off[5:0];
						e_dist       = (cand_d > SUM_W'(DIST_MAX)) ? DIST_MAX
						                                           : cand_d[DIST_W-1:0];
						e_hit        = (cand_h == HIT_MAX) ? HIT_MAX : cand_h + 1'b1;
						e_last       = is_last_net;
						ctl.bump_en  = 1'b1;
						ctl.bump_idx = IDX_W'(cand_i);
						ctl.shift    = 1'b1;
						idx_d        = idx_q + 1'b1;
						net_d        = net_q + 3'd1;
						start_d      = start_next;
						if (is_last_net) state_d = ST_IDLE;
					end
				end else begin
					ctl.shift = 1'b1;
					idx_d     = idx_q + 1'b1;
					best_d_d  = cand_d;
					best_i_d  = cand_i;
					best_h_d  = cand_h;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_read_q <= 1'b0;
			oob_q       <= 1'b0;
			target_q    <= '0;
			idx_q       <= '0;
			start_q     <= '0;
			net_q       <= '0;
			out_valid_q <= 1'b0;
			fc_q        <= 5'd16;
			nc_q        <= 3'd3;
			size_q[0]   <= 7'd9;
			size_q[1]   <= 7'd16;
			size_q[2]   <= 7'd25;
			size_q[3]   <= 7'd1;
		end else begin
			state_q     <= state_d;
			mode_read_q <= mode_read_d;
			oob_q       <= oob_d;
			target_q    <= target_d;
			idx_q       <= idx_d;
			start_q     <= start_d;
			net_q       <= net_d;
			if (emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_FEATURES: fc_q <= cfg_data[4:0];
					CFG_NETS:     nc_q <= cfg_data[2:0];
					CFG_NET0:     size_q[0] <= cfg_data;
					CFG_NET1:     size_q[1] <= cfg_data;
					CFG_NET2:     size_q[2] <= cfg_data;
					CFG_NET3:     size_q[3] <= cfg_data;
					default:      ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		best_d_q <= best_d_d;
		best_i_q <= best_i_d;
		best_h_q <= best_h_d;
		if (emit) begin
			out_kind_q <= e_kind;
			out_net_q  <= e_net;
			out_win_q  <= e_win;
			out_dist_q <= e_dist;
			out_hit_q  <= e_hit;
			out_last_q <= e_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {3'd0, out_hit_q, out_dist_q, out_win_q, out_net_q};

	a_bump_emits: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.bump_en |=> (m_tvalid && (m_tuser == KIND_WIN)))
		else $error("hit counter bumped without a winner result");

	a_net_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && !mode_read_q && !empty && idx_q < start_q) |-> 1'b0)
		else $error("scan index fell behind the start of the current net");

	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && e_kind == KIND_READ) |-> e_last)
		else $error("readback result without last flag");

endmodule
`default_nettype wire
